@@ rtl/tks_pkg.sv @@
// Shared types, codes and constants for the top-k insertion sorter.
package tks_pkg;

   localparam int DEF_MAX_ENTRIES = 64;
   localparam logic [6:0] CAP_RESET = 7'd64;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_READ   = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;

   localparam logic [2:0] ST_INSERTED     = 3'd0;
   localparam logic [2:0] ST_EVICTED      = 3'd1;
   localparam logic [2:0] ST_DROPPED      = 3'd2;
   localparam logic [2:0] ST_READ_OK      = 3'd3;
   localparam logic [2:0] ST_OUT_OF_RANGE = 3'd4;
   localparam logic [2:0] ST_CLEARED      = 3'd5;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [63:0] key;
      logic [5:0]         index;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [63:0] value_out;
      logic [5:0]         position;
      logic [6:0]         count;
   } rsp_item_type;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic compare;    // latch compare and read-select flags
      logic ins_open;   // insert into a list that is not full
      logic ins_full;   // insert with eviction of the smallest entry
   } cell_ctl_type;

endpackage

@@ rtl/top_k_sorted_list_insert_core.sv @@
// Top level of the top-k insertion sorter: control, chain of cells and result register.
//
// The block keeps an ascending list of the largest keys seen, one key per cell.
// Items arrive on the req_ channel (valid/stall) carrying a mode, a key and an
// index; each item that is not the unused mode gives exactly one result on the
// rsp_ channel (valid/stall). The capacity register is written through csr_wr_en
// and csr_wr_data; the user must do so only while no item is in flight, which
// the block itself does not enforce. In the compare step every cell compares the
// key with its entry at once and latches the outcome; in the apply step, once the
// output register is free, each cell takes its new entry from itself, the key or
// a neighbour, and the result is registered. A new item is taken only while the
// block is idle or as the previous item finishes its apply step.
// While a finished result waits under rsp_stall the next item is still taken
// and compared, and its result is written once the output register is free.
// Reset (synchronous, active high) empties the list, sets the capacity to 64
// and drops any pending result; entry contents are not cleared.
module top_k_sorted_list_insert_core #(
   parameter int MAX_ENTRIES = tks_pkg::DEF_MAX_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tks_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tks_pkg::rsp_item_type rsp_item,
   input  logic                  csr_wr_en,
   input  logic [6:0]            csr_wr_data
);
   import tks_pkg::*;

   localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
   localparam int CAP_W  = (FILL_W > 7) ? FILL_W : 7;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CMP   = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]         state_ff, state_in;
   req_item_type       item_ff, item_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [6:0]         cap_ff, cap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic               out_free, req_take, finish;
   logic [CAP_W-1:0]   cap_eff;
   logic               full;
   cell_ctl_type       ctl;

   logic               s_w    [MAX_ENTRIES];
   logic               mark_w [MAX_ENTRIES];
   logic signed [63:0] e_w    [MAX_ENTRIES];
   logic signed [63:0] rd_w   [MAX_ENTRIES];

   logic signed [63:0] rd_any;
   logic [FILL_W-1:0]  slot_enc;
   logic               slot_hit;
   logic [FILL_W-1:0]  slot;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == S_APPLY) && out_free;
   assign req_stall = !((state_ff == S_IDLE) || finish);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cap_eff = {{(CAP_W - 7){1'b0}}, cap_ff};
      if (cap_ff == 7'd0) begin
         cap_eff = CAP_W'(1);
      end
      if (cap_eff > CAP_W'(MAX_ENTRIES)) begin
         cap_eff = CAP_W'(MAX_ENTRIES);
      end
   end

   assign full = {{(CAP_W - FILL_W){1'b0}}, fill_ff} >= cap_eff;

   // A full list drops the key when it lies below the smallest entry.
   always_comb begin
      ctl.compare  = (state_ff == S_CMP);
      ctl.ins_open = finish && (item_ff.mode == MODE_INSERT) && !full;
      ctl.ins_full = finish && (item_ff.mode == MODE_INSERT) && full && !s_w[0];
   end

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic               sp, sn;
      logic signed [63:0] ep, en;
      if (i == 0) begin : g_first
         assign sp = 1'b0;
         assign ep = e_w[0];
      end else begin : g_mid_lo
         assign sp = s_w[i-1];
         assign ep = e_w[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign sn = 1'b1;
         assign en = e_w[i];
      end else begin : g_mid_hi
         assign sn = s_w[i+1];
         assign en = e_w[i+1];
      end
      tks_cell #(
         .CELL_ID (i),
         .FILL_W  (FILL_W)
      ) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .key     (item_ff.key),
         .fill    (fill_ff),
         .index   (item_ff.index),
         .s_prev  (sp),
         .s_next  (sn),
         .e_prev  (ep),
         .e_next  (en),
         .s       (s_w[i]),
         .mark    (mark_w[i]),
         .entry   (e_w[i]),
         .rd_data (rd_w[i])
      );
   end

   // At most one cell is selected for a read and at most one marks the slot.
   always_comb begin
      rd_any   = 64'sd0;
      slot_enc = '0;
      slot_hit = 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rd_any   = rd_any | rd_w[i];
         slot_enc = slot_enc | (mark_w[i] ? FILL_W'(i) : FILL_W'(0));
         slot_hit = slot_hit | mark_w[i];
      end
   end

   assign slot = slot_hit ? slot_enc : fill_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      fill_in      = fill_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;

      if (finish) begin
         state_in = S_IDLE;
         rsp_item_in.value_out = 64'sd0;
         rsp_item_in.position  = 6'd0;
         rsp_valid_in          = 1'b1;
         case (item_ff.mode)
            MODE_INSERT: begin
               if (!full) begin
                  rsp_item_in.status   = ST_INSERTED;
                  rsp_item_in.position = 6'(slot);
                  fill_in              = fill_ff + FILL_W'(1);
               end else if (s_w[0]) begin
                  rsp_item_in.status = ST_DROPPED;
               end else begin
                  rsp_item_in.status    = ST_EVICTED;
                  rsp_item_in.value_out = e_w[0];
                  rsp_item_in.position  = 6'(slot - FILL_W'(1));
               end
            end
            MODE_READ: begin
               if ({{(CAP_W - 6){1'b0}}, item_ff.index} <
                   {{(CAP_W - FILL_W){1'b0}}, fill_ff}) begin
                  rsp_item_in.status    = ST_READ_OK;
                  rsp_item_in.value_out = rd_any;
               end else begin
                  rsp_item_in.status = ST_OUT_OF_RANGE;
               end
            end
            MODE_CLEAR: begin
               rsp_item_in.status = ST_CLEARED;
               fill_in            = '0;
            end
            default: begin
               // The unused mode leaves the state alone and gives no item.
               rsp_item_in  = rsp_item_ff;
               rsp_valid_in = rsp_valid_ff && rsp_stall;
            end
         endcase
         rsp_item_in.count = 7'(fill_in);
      end else if (state_ff == S_CMP) begin
         state_in = S_APPLY;
      end

      if (req_take) begin
         item_in  = req_item;
         state_in = S_CMP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ rtl/tks_cell.sv @@
// One cell of the sorted chain: holds one entry and trades with its neighbours.
module tks_cell #(
   parameter int CELL_ID = 0,
   parameter int FILL_W  = 7
) (
   input  logic                 clock,
   input  tks_pkg::cell_ctl_type ctl,
   input  logic signed [63:0]   key,
   input  logic [FILL_W-1:0]    fill,
   input  logic [5:0]           index,
   input  logic                 s_prev,
   input  logic                 s_next,
   input  logic signed [63:0]   e_prev,
   input  logic signed [63:0]   e_next,
   output logic                 s,
   output logic                 mark,
   output logic signed [63:0]   entry,
   output logic signed [63:0]   rd_data
);
   import tks_pkg::*;

   logic signed [63:0] entry_ff, entry_in;
   logic               s_ff, s_in;
   logic               sel_ff, sel_in;
   logic               held;

   // A cell is held when its place lies below the fill count.
   assign held = 32'(CELL_ID) < {{(32 - FILL_W){1'b0}}, fill};

   always_comb begin
      s_in   = s_ff;
      sel_in = sel_ff;
      if (ctl.compare) begin
         // The new key belongs at or before this place.
         s_in   = !held || ($signed(key) < $signed(entry_ff));
         sel_in = held && ({26'd0, index} == 32'(CELL_ID));
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins_open && s_ff) begin
         entry_in = s_prev ? e_prev : key;
      end else if (ctl.ins_full && s_next) begin
         if (!s_ff) begin
            entry_in = key;
         end
      end else if (ctl.ins_full) begin
         entry_in = e_next;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      s_ff     <= s_in;
      sel_ff   <= sel_in;
   end

   assign s       = s_ff;
   assign mark    = s_ff && !s_prev;
   assign entry   = entry_ff;
   assign rd_data = sel_ff ? entry_ff : 64'sd0;

endmodule

@@ rtl/tks_check.sv @@
// Port-level checks for the top-k insertion sorter, bound to the top level.
module tks_check (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input tks_pkg::req_item_type req_item,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input tks_pkg::rsp_item_type rsp_item
);
   import tks_pkg::*;

   // An accepted item keeps the input channel closed for its compare cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken in the cycle after an accepted item");

   // Only an eviction or a good read carries a value.
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != ST_EVICTED && rsp_item.status != ST_READ_OK
      |-> rsp_item.value_out == 64'sd0)
      else $error("value_out not zero for this status");

   // A cleared list holds nothing, and a clear result carries no position.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == ST_CLEARED
      |-> rsp_item.count == 7'd0 && rsp_item.position == 6'd0)
      else $error("clear result reports entries or a position");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result changed or vanished");

endmodule

bind top_k_sorted_list_insert_core tks_check u_tks_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the top-k insertion sorter: directed table, then random phases.
module testbench;
   import tks_pkg::*;

   localparam int LIST_DEPTH = DEF_MAX_ENTRIES;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic signed [63:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] KEY_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic         is_cap;
      logic         typed;
      logic [6:0]   cap;
      req_item_type item;
      rsp_item_type want;
   } plan_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_wr_en = 1'b0;
   logic [6:0]   csr_wr_data = '0;

   top_k_sorted_list_insert_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Predicted state of the list and the capacity register.
   logic signed [63:0] sorted_keys [LIST_DEPTH];
   int                 held = 0;
   logic [6:0]         capacity_reg = CAP_RESET;

   rsp_item_type expected_results [$];
   plan_row_type plan [$];

   int errors = 0;
   int items_sent = 0;
   int items_ignored = 0;
   int cap_writes = 0;
   int burst_left = 0;
   int status_seen [6] = '{default: 0};

   function automatic bit sorter_step(input req_item_type it, output rsp_item_type res);
      int eff;
      int slot;
      int i;
      res = '0;
      eff = int'(capacity_reg);
      if (eff == 0) eff = 1;
      if (eff > LIST_DEPTH) eff = LIST_DEPTH;
      case (it.mode)
         MODE_INSERT: begin
            if (held >= eff && held > 0) begin
               if (it.key < sorted_keys[0]) begin
                  res.status = ST_DROPPED;
               end else begin
                  // The first strictly greater entry, searched from the top down.
                  slot = held;
                  for (i = held - 1; i >= 1; i--)
                     if (it.key < sorted_keys[i]) slot = i;
                  res.value_out = sorted_keys[0];
                  for (i = 0; i + 1 < slot; i++) sorted_keys[i] = sorted_keys[i + 1];
                  sorted_keys[slot - 1] = it.key;
                  res.position = 6'(slot - 1);
                  res.status = ST_EVICTED;
               end
            end else begin
               slot = held;
               for (i = held - 1; i >= 0; i--)
                  if (it.key < sorted_keys[i]) slot = i;
               for (i = held; i > slot; i--) sorted_keys[i] = sorted_keys[i - 1];
               sorted_keys[slot] = it.key;
               held++;
               res.position = 6'(slot);
               res.status = ST_INSERTED;
            end
         end
         MODE_READ: begin
            if (int'(it.index) < held) begin
               res.status = ST_READ_OK;
               res.value_out = sorted_keys[it.index];
            end else begin
               res.status = ST_OUT_OF_RANGE;
            end
         end
         MODE_CLEAR: begin
            held = 0;
            res.status = ST_CLEARED;
         end
         default: return 1'b0;
      endcase
      res.count = 7'(held);
      return 1'b1;
   endfunction

   function automatic void add_item(logic [1:0] m, logic signed [63:0] k, logic [5:0] ix);
      plan_row_type row;
      row = '0;
      row.item.mode = m;
      row.item.key = k;
      row.item.index = ix;
      plan.push_back(row);
   endfunction

   function automatic void add_typed(logic [1:0] m, logic signed [63:0] k, logic [5:0] ix,
                                     logic [2:0] st, logic signed [63:0] v, logic [5:0] p,
                                     logic [6:0] c);
      plan_row_type row;
      row = '0;
      row.typed = 1'b1;
      row.item.mode = m;
      row.item.key = k;
      row.item.index = ix;
      row.want.status = st;
      row.want.value_out = v;
      row.want.position = p;
      row.want.count = c;
      plan.push_back(row);
   endfunction

   function automatic void add_cap(logic [6:0] c);
      plan_row_type row;
      row = '0;
      row.is_cap = 1'b1;
      row.cap = c;
      plan.push_back(row);
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send(input req_item_type it, input bit typed, input rsp_item_type want);
      rsp_item_type res;
      bit           has;
      int           gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 10);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has = sorter_step(it, res);
      if (has) begin
         expected_results.push_back(typed ? want : res);
         items_sent++;
      end else begin
         items_ignored++;
      end
      burst_left--;
      @(negedge clock);
   endtask

   // Stops the sender and waits for every outstanding result, then waits out the extra delay.
   task automatic drain(input int extra);
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic set_capacity(input logic [6:0] c);
      csr_wr_en <= 1'b1;
      csr_wr_data <= c;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      capacity_reg = c;
      cap_writes++;
   endtask

   // The receiver changes its stall style at random among none, light, heavy and a repeating pattern.
   int stall_cycle = 0;
   int stall_style = 0;
   always @(negedge clock) begin
      if (stall_cycle % 256 == 0) stall_style = $urandom_range(0, 3);
      stall_cycle++;
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         2: rsp_stall <= ($urandom_range(0, 99) < 75);
         default: rsp_stall <= ((stall_cycle % 7) < 3);
      endcase
   end

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result with no item outstanding: status %0d value_out %0d",
                   rsp_item.status, rsp_item.value_out);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_item.status < 6) status_seen[rsp_item.status]++;
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               errors++;
            end
            if (rsp_item.value_out !== want.value_out) begin
               $error("value_out: expected %0d, got %0d", want.value_out, rsp_item.value_out);
               errors++;
            end
            if (rsp_item.position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_item.position);
               errors++;
            end
            if (rsp_item.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_item.count);
               errors++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int           phase_caps [12];
      int           p;
      int           n;
      int           phase_len;
      int           clear_pct;
      int           r;
      int           top;
      req_item_type it;
      rsp_item_type none;

      phase_caps = '{1, 3, 64, 0, 2, 127, 5, 8, 64, 100, 4, 16};
      none = '0;

      // Empty list after reset, then the extremes of the key and equal keys.
      add_typed(MODE_READ, 64'sd0, 6'd0, ST_OUT_OF_RANGE, 64'sd0, 6'd0, 7'd0);
      add_typed(MODE_READ, KEY_MIN, 6'd63, ST_OUT_OF_RANGE, 64'sd0, 6'd0, 7'd0);
      add_typed(MODE_INSERT, KEY_MAX, 6'd0, ST_INSERTED, 64'sd0, 6'd0, 7'd1);
      add_typed(MODE_INSERT, KEY_MIN, 6'd63, ST_INSERTED, 64'sd0, 6'd0, 7'd2);
      add_item(MODE_INSERT, 64'sd0, 6'd0);
      add_item(MODE_INSERT, 64'sd0, 6'd21);
      add_typed(MODE_READ, 64'sd0, 6'd0, ST_READ_OK, KEY_MIN, 6'd0, 7'd4);
      add_item(MODE_READ, KEY_MAX, 6'd3);
      add_typed(MODE_READ, 64'sd0, 6'd4, ST_OUT_OF_RANGE, 64'sd0, 6'd0, 7'd4);
      add_item(MODE_UNUSED, -64'sd1, 6'd63);
      // Capacity lowered below the number of entries held.
      add_cap(7'd2);
      add_item(MODE_INSERT, 64'sd1, 6'd0);
      add_typed(MODE_INSERT, KEY_MIN, 6'd0, ST_DROPPED, 64'sd0, 6'd0, 7'd4);
      add_typed(MODE_CLEAR, KEY_MAX, 6'd63, ST_CLEARED, 64'sd0, 6'd0, 7'd0);
      // A capacity of zero acts as one; an equal key evicts rather than drops.
      add_cap(7'd0);
      add_typed(MODE_INSERT, 64'sd5, 6'd0, ST_INSERTED, 64'sd0, 6'd0, 7'd1);
      add_typed(MODE_INSERT, 64'sd3, 6'd0, ST_DROPPED, 64'sd0, 6'd0, 7'd1);
      add_typed(MODE_INSERT, 64'sd5, 6'd0, ST_EVICTED, 64'sd5, 6'd0, 7'd1);
      add_item(MODE_INSERT, -64'sd1, 6'd0);
      add_item(MODE_INSERT, KEY_MAX, 6'd0);
      // A capacity above the list depth saturates.
      add_cap(7'd127);
      add_item(MODE_INSERT, KEY_MIN, 6'd0);
      add_item(MODE_READ, 64'sd0, 6'd1);
      add_typed(MODE_CLEAR, 64'sd0, 6'd0, ST_CLEARED, 64'sd0, 6'd0, 7'd0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < plan.size(); i++) begin
         if (plan[i].is_cap) begin
            drain(8);
            set_capacity(plan[i].cap);
         end else begin
            send(plan[i].item, plan[i].typed, plan[i].want);
         end
      end

      for (p = 0; p < 12; p++) begin
         drain(8);
         set_capacity(7'(phase_caps[p]));
         // Large capacities only fill up when clears stay away.
         phase_len = (phase_caps[p] >= 32) ? 140 : 70;
         clear_pct = (phase_caps[p] >= 32) ? 0 : 4;
         n = 0;
         while (n < phase_len) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  it.key = 64'($urandom_range(0, 16));
                  it.key = it.key - 64'sd8;
               end
               4: it.key = KEY_MAX - 64'($urandom_range(0, 3));
               5: it.key = KEY_MIN + 64'($urandom_range(0, 3));
               default: it.key = {$urandom, $urandom};
            endcase
            it.index = 6'($urandom_range(0, 63));
            r = $urandom_range(0, 99);
            if (r < 2) begin
               it.mode = MODE_UNUSED;
            end else if (r < 2 + clear_pct) begin
               it.mode = MODE_CLEAR;
            end else if (r < 32) begin
               it.mode = MODE_READ;
               if ($urandom_range(0, 1) == 1) begin
                  top = (held + 1 > 63) ? 63 : held + 1;
                  it.index = 6'($urandom_range(0, top));
               end
            end else begin
               it.mode = MODE_INSERT;
            end
            send(it, 1'b0, none);
            if (it.mode != MODE_UNUSED) n++;
         end
      end

      drain(10);
      $display("Sent %0d items (%0d ignored) over %0d capacity writes.",
               items_sent, items_ignored, cap_writes);
      $display("Results: %0d inserted, %0d evicted, %0d dropped, %0d read, %0d out of range, %0d cleared.",
               status_seen[ST_INSERTED], status_seen[ST_EVICTED], status_seen[ST_DROPPED],
               status_seen[ST_READ_OK], status_seen[ST_OUT_OF_RANGE], status_seen[ST_CLEARED]);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
